@@ sv/mbps_pkg.sv @@
`timescale 1ns / 1ps
package mbps_pkg;

   localparam int BYTE_WIDTH                = 8;
   localparam int PATTERN_BYTES             = 16;
   localparam int LENGTH_WIDTH              = 5;
   localparam int POSITION_WIDTH            = 32;
   localparam int SITE_WIDTH                = POSITION_WIDTH + 2;
   localparam int CSR_INDEX_WIDTH           = 3;
   localparam int CSR_DATA_WIDTH            = 64;
   localparam int DEFAULT_MAX_PATTERN_BYTES = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_MASK   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SITE_OFFSET    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_SIZE    = 3'd5;

   typedef logic [BYTE_WIDTH-1:0] byte_type;

   typedef struct packed {
      logic     care;
      byte_type expect_byte;
   } cell_cfg_type;

   // Cell d sits d places behind the newest byte, so it faces pattern byte len-1-d.
   function automatic cell_cfg_type cell_config(
      input logic [LENGTH_WIDTH-1:0]              len,
      input logic [PATTERN_BYTES-1:0]             mask,
      input logic [PATTERN_BYTES*BYTE_WIDTH-1:0]  pattern,
      input int                                   d
   );
      cell_cfg_type             cfg;
      logic [LENGTH_WIDTH-1:0]  kk;
      logic [3:0]               k;
      kk = len - LENGTH_WIDTH'(1) - LENGTH_WIDTH'(d);
      k  = kk[3:0];
      cfg.care        = (32'(len) > 32'(d)) && (32'(len) <= 32'(PATTERN_BYTES)) && mask[k];
      cfg.expect_byte = pattern[32'(k)*BYTE_WIDTH +: BYTE_WIDTH];
      return cfg;
   endfunction

endpackage

@@ sv/mbps_req_if.sv @@
`timescale 1ns / 1ps
interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/mbps_rsp_if.sv @@
`timescale 1ns / 1ps
interface mbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [31:0] site_position;

   modport source (output valid, output match_found, output site_position, input ready);
   modport sink   (input valid, input match_found, input site_position, output ready);
endinterface

@@ sv/mbps_cell.sv @@
`timescale 1ns / 1ps
module mbps_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic                  clear,
   input  mbps_pkg::cell_cfg_type cfg,
   input  mbps_pkg::byte_type    byte_in,
   output mbps_pkg::byte_type    byte_out,
   output logic                  hit_out
);

   mbps_pkg::byte_type byte_ff;
   logic               hit_ff;
   logic               hit_in;

   assign hit_in = !cfg.care || (byte_in == cfg.expect_byte);

   // The hit belongs to the beat just shifted in; the byte drops on region end.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         hit_ff  <= hit_in;
         byte_ff <= clear ? '0 : byte_in;
      end
   end

   assign byte_out = byte_ff;
   assign hit_out  = hit_ff;

endmodule

@@ sv/masked_byte_pattern_scanner_core.sv @@
`timescale 1ns / 1ps
// A result passes from the compare cells and stage A registers into the result register.
// One byte per cycle moves through the shift chain of compare cells while not stalled.
// The input stalls only while a new result meets an earlier one not yet taken.
// Reset (synchronous, active high) clears configuration, position, valids and scan state;
// window bytes are not cleared and are never compared before a region refills them.
module masked_byte_pattern_scanner_core #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   mbps_req_if.sink                             req_if,
   mbps_rsp_if.source                           rsp_if
);

   import mbps_pkg::*;

   logic [63:0]               pattern_low_ff;
   logic [63:0]               pattern_high_ff;
   logic [PATTERN_BYTES-1:0]  pattern_mask_ff;
   logic [LENGTH_WIDTH-1:0]   pattern_length_ff;
   logic [31:0]               site_offset_ff;
   logic [POSITION_WIDTH-1:0] region_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_mask_ff   <= '0;
         pattern_length_ff <= '0;
         site_offset_ff    <= '0;
         region_size_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            CSR_PATTERN_MASK:   pattern_mask_ff   <= csr_write_data[PATTERN_BYTES-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[LENGTH_WIDTH-1:0];
            CSR_SITE_OFFSET:    site_offset_ff    <= csr_write_data[31:0];
            CSR_REGION_SIZE:    region_size_ff    <= csr_write_data[POSITION_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- cell chain ----------------
   cell_cfg_type             cell_cfg [MAX_PATTERN_BYTES];
   byte_type                 window   [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] care_vec;
   logic [MAX_PATTERN_BYTES-1:0] hit_vec;
   logic                     accept;
   logic                     stall;

   assign req_if.ready = !stall;
   assign accept       = req_if.valid && !stall;

   for (genvar d = 0; d < MAX_PATTERN_BYTES; d++) begin : g_cell
      assign cell_cfg[d] = cell_config(pattern_length_ff, pattern_mask_ff,
                                       {pattern_high_ff, pattern_low_ff}, d);
      assign care_vec[d] = cell_cfg[d].care;
      if (d == 0) begin : g_head
         mbps_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .clear    (req_if.last_byte),
            .cfg      (cell_cfg[d]),
            .byte_in  (req_if.data_byte),
            .byte_out (window[d]),
            .hit_out  (hit_vec[d])
         );
      end else begin : g_body
         mbps_cell u_cell (
            .clock    (clock),
            .shift_en (accept),
            .clear    (req_if.last_byte),
            .cfg      (cell_cfg[d]),
            .byte_in  (window[d-1]),
            .byte_out (window[d]),
            .hit_out  (hit_vec[d])
         );
      end
   end

   // ---------------- position and site ----------------
   logic                      pattern_ok;
   logic [POSITION_WIDTH-1:0] pos_ff;
   logic [POSITION_WIDTH-1:0] pos_in;
   logic                      pos_ok_in;
   logic [SITE_WIDTH-1:0]     site_in;

   assign pattern_ok = (pattern_length_ff != '0)
                    && (32'(pattern_length_ff) <= 32'(PATTERN_BYTES))
                    && (32'(pattern_length_ff) <= 32'(MAX_PATTERN_BYTES))
                    && (|care_vec);

   assign pos_ok_in = pattern_ok
                   && (pos_ff != '1)
                   && (pos_ff < region_size_ff)
                   && (({1'b0, pos_ff} + 33'd1) >= 33'(pattern_length_ff));

   assign site_in = {2'b00, pos_ff}
                  + {{2{site_offset_ff[31]}}, site_offset_ff}
                  + SITE_WIDTH'(1)
                  - SITE_WIDTH'(pattern_length_ff);

   // Saturate at all ones; restart on region end.
   assign pos_in = req_if.last_byte ? '0 : ((pos_ff == '1) ? pos_ff : pos_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   // ---------------- stage A: beat at the compare point ----------------
   logic                  valid_a_ff;
   logic                  last_a_ff;
   logic                  pos_ok_a_ff;
   logic [SITE_WIDTH-1:0] site_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (!stall) begin
         valid_a_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_a_ff   <= req_if.last_byte;
         pos_ok_a_ff <= pos_ok_in;
         site_a_ff   <= site_in;
      end
   end

   // ---------------- decision and result register ----------------
   logic        done_ff;
   logic        done_in;
   logic        site_ok;
   logic        found;
   logic        emit;
   logic        rsp_valid_ff;
   logic        match_found_ff;
   logic [31:0] site_position_ff;

   assign site_ok = !site_a_ff[SITE_WIDTH-1] && !site_a_ff[SITE_WIDTH-2]
                 && (site_a_ff[POSITION_WIDTH-1:0] < region_size_ff);
   assign found   = valid_a_ff && !done_ff && pos_ok_a_ff && (&hit_vec) && site_ok;
   assign emit    = found || (valid_a_ff && last_a_ff && !done_ff);
   assign stall   = emit && rsp_valid_ff && !rsp_if.ready;
   assign done_in = last_a_ff ? 1'b0 : (done_ff || found);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (valid_a_ff && !stall) begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && !stall) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && !stall) begin
         match_found_ff   <= found;
         site_position_ff <= found ? site_a_ff[POSITION_WIDTH-1:0] : '0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.match_found   = match_found_ff;
   assign rsp_if.site_position = site_position_ff;

endmodule
